// ===== hw/rtl/rbd_pkg.sv =====
// Shared types, sizes, operation codes and word conversions for the ring buffer deque.
package rbd_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 32;
    localparam int OCC_W   = 11;
    localparam int WIDE_W  = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int OCCX_W  = (CNT_W > OCC_W) ? CNT_W : OCC_W;

    typedef logic [FUNC_W-1:0]         t_func;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [DATA_WIDTH-1:0]     t_word;
    typedef logic [PTR_W-1:0]          t_ptr;
    typedef logic [CNT_W-1:0]          t_count;
    typedef logic [OCC_W-1:0]          t_occ;

    localparam t_func FUNC_PUSH_FRONT = 2'd0;
    localparam t_func FUNC_POP_FRONT  = 2'd1;
    localparam t_func FUNC_PUSH_BACK  = 2'd2;
    localparam t_func FUNC_POP_BACK   = 2'd3;

    // Control broadcast to every cell of one chain in a cycle.
    typedef struct packed {
        logic  ins;   // insert at the head: every cell takes its left neighbor
        logic  rem;   // remove at the head: every cell takes its right neighbor
        logic  app;   // append at the tail: the cell at tail takes word
        t_ptr  tail;
        t_word word;
    } t_cell_ctrl;

    // Incoming values are zero-extended to the stored width, then masked to it.
    function automatic t_word to_word(input t_value v);
        logic [WIDE_W-1:0] x;
        x = WIDE_W'($unsigned(v));
        return x[DATA_WIDTH-1:0];
    endfunction

    // A stored word is read back as its low bits, zero-extended where it is narrow.
    function automatic t_value from_word(input t_word w);
        logic [WIDE_W-1:0] x;
        x = WIDE_W'(w);
        return $signed(x[VALUE_W-1:0]);
    endfunction

endpackage

// ===== hw/rtl/rbd_chan_if.sv =====
// Valid/ready channel interfaces for the deque's operation input and result output.
interface rbd_in_if;
    logic            valid;
    logic            ready;
    rbd_pkg::t_func  func;
    rbd_pkg::t_value value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface rbd_out_if;
    logic            valid;
    logic            ready;
    rbd_pkg::t_value popped;
    logic            matched;
    logic            was_empty;
    logic            overflow;
    rbd_pkg::t_occ   occupancy;

    modport source (output valid, output popped, output matched, output was_empty,
                    output overflow, output occupancy, input ready);
    modport sink   (input valid, input popped, input matched, input was_empty,
                    input overflow, input occupancy, output ready);
endinterface

// ===== hw/rtl/rbd_cell.sv =====
// One storage cell of a deque chain: holds a word and shifts it toward either neighbor.
module rbd_cell (
    input  logic                i_clk,
    input  rbd_pkg::t_cell_ctrl i_ctrl,
    input  rbd_pkg::t_ptr       i_index,
    input  rbd_pkg::t_word      i_left,
    input  rbd_pkg::t_word      i_right,
    output rbd_pkg::t_word      o_word
);
    import rbd_pkg::*;

    t_word r_word;
    t_word n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctrl.ins) begin
            n_word = i_left;
        end else if (i_ctrl.rem) begin
            n_word = i_right;
        end else if (i_ctrl.app && (i_index == i_ctrl.tail)) begin
            n_word = i_ctrl.word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ===== hw/rtl/rbd_chain.sv =====
// A row of deque cells whose head sits at cell zero; words leave at the head and enter at the head or the tail.
module rbd_chain (
    input  logic                i_clk,
    input  rbd_pkg::t_cell_ctrl i_ctrl,
    output rbd_pkg::t_word      o_head
);
    import rbd_pkg::*;

    t_word w_cell [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word w_left;
        t_word w_right;

        if (g == 0) begin : g_first
            assign w_left = i_ctrl.word;
        end else begin : g_inner_l
            assign w_left = w_cell[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_cell[g];
        end else begin : g_inner_r
            assign w_right = w_cell[g+1];
        end

        rbd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (i_ctrl),
            .i_index (PTR_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_cell[g])
        );
    end

    assign o_head = w_cell[0];

endmodule

// ===== hw/rtl/ring_buffer_deque.sv =====
// Top level of the ring buffer deque: operation decode, occupancy count and result register.
//
// The deque takes one operation transaction per clock cycle and returns exactly one
// result transaction for each, in the cycle after acceptance; a result waiting in the output
// register does not stop the next operation as long as the sink takes it in the same
// cycle. The contents live in two chains of DEPTH cells: the front chain keeps the front
// word in its first cell and the back chain keeps the back word in its first cell, each
// holding the whole deque in opposite order. A push at one end shifts that end's chain by
// one cell and writes the word into the free cell just past the tail of the other chain;
// a pop at one end shifts that end's chain back by one and simply shortens the other.
// Every pop therefore reads a first cell directly, with no addressed memory access. A pop
// from an empty deque returns all ones with was_empty set, and a push to a full deque is
// dropped with overflow set. The cells need no clearing after reset, since a pop only ever
// reads words that an earlier push wrote; reset clears just the count and the output
// valid flag.
module ring_buffer_deque (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rbd_in_if.sink    i_in,
    rbd_out_if.source o_out
);
    import rbd_pkg::*;

    t_count r_count;
    t_count n_count;

    logic   r_valid;
    t_value r_popped;
    logic   r_matched;
    logic   r_was_empty;
    logic   r_overflow;
    t_occ   r_occupancy;

    t_value n_popped;
    logic   n_matched;

    logic   w_accept;
    logic   w_is_push;
    logic   w_at_front;
    logic   w_full;
    logic   w_empty;
    logic   w_do_push;
    logic   w_do_pop;
    t_word  w_word;
    t_word  w_front_head;
    t_word  w_back_head;
    logic [OCCX_W-1:0] w_occ_ext;

    t_cell_ctrl w_front_ctrl;
    t_cell_ctrl w_back_ctrl;

    // A new transaction is taken whenever the result register is free or being emptied.
    assign i_in.ready = !r_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_is_push  = (i_in.func == FUNC_PUSH_FRONT) || (i_in.func == FUNC_PUSH_BACK);
    assign w_at_front = (i_in.func == FUNC_PUSH_FRONT) || (i_in.func == FUNC_POP_FRONT);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_do_push  = w_accept && w_is_push && !w_full;
    assign w_do_pop   = w_accept && !w_is_push && !w_empty;
    assign w_word     = to_word(i_in.value);

    // The tail index is only used on a push, when the count is below DEPTH.
    always_comb begin
        w_front_ctrl.ins  = w_do_push && w_at_front;
        w_front_ctrl.rem  = w_do_pop && w_at_front;
        w_front_ctrl.app  = w_do_push && !w_at_front;
        w_front_ctrl.tail = r_count[PTR_W-1:0];
        w_front_ctrl.word = w_word;

        w_back_ctrl.ins   = w_do_push && !w_at_front;
        w_back_ctrl.rem   = w_do_pop && !w_at_front;
        w_back_ctrl.app   = w_do_push && w_at_front;
        w_back_ctrl.tail  = r_count[PTR_W-1:0];
        w_back_ctrl.word  = w_word;
    end

    rbd_chain u_front_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_front_ctrl),
        .o_head (w_front_head)
    );

    rbd_chain u_back_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_back_ctrl),
        .o_head (w_back_head)
    );

    always_comb begin
        n_count = r_count;
        if (w_do_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Pushes report zero; an empty pop reports all ones.
    always_comb begin
        if (w_is_push) begin
            n_popped = '0;
        end else if (w_empty) begin
            n_popped = '1;
        end else if (w_at_front) begin
            n_popped = from_word(w_front_head);
        end else begin
            n_popped = from_word(w_back_head);
        end
        n_matched = !w_is_push && (n_popped == i_in.value);
    end

    assign w_occ_ext = OCCX_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped    <= n_popped;
            r_matched   <= n_matched;
            r_was_empty <= !w_is_push && w_empty;
            r_overflow  <= w_is_push && w_full;
            r_occupancy <= w_occ_ext[OCC_W-1:0];
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.popped    = r_popped;
    assign o_out.matched   = r_matched;
    assign o_out.was_empty = r_was_empty;
    assign o_out.overflow  = r_overflow;
    assign o_out.occupancy = r_occupancy;

endmodule
